// ----- hw/rtl/sms_pkg.sv -----
// Shared constants, types and the store address function for the sorted matrix search.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package sms_pkg;

   localparam int MAX_DIM    = 16;
   localparam int DATA_WIDTH = 32;
   localparam int KEY_WIDTH  = 32;
   localparam int POS_W      = 4;
   localparam int SIZE_W     = 5;

   localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = ($clog2(MAX_DIM + 1) > SIZE_W) ? $clog2(MAX_DIM + 1) : SIZE_W;
   localparam int CMP_W  = (DATA_WIDTH > KEY_WIDTH) ? DATA_WIDTH : KEY_WIDTH;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SEARCH_MODE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MATRIX_SIZE = CSR_IDX_W'(1);

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   localparam logic MODE_ROW   = 1'b0;
   localparam logic MODE_STAIR = 1'b1;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);

   typedef struct packed {
      logic             mode;
      logic [CNT_W-1:0] dim;
   } sms_ctl_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] hit_row;
      logic [POS_W-1:0] hit_col;
   } sms_res_type;

   // Row-major word address of one matrix entry.
   function automatic logic [ADDR_W-1:0] sms_addr(input logic [IDX_W-1:0] row,
                                                 input logic [IDX_W-1:0] col);
      sms_addr = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_DIM)) + ADDR_W'(col);
   endfunction

endpackage

// ----- hw/rtl/sms_store.sv -----
// Matrix storage: one write port, one read port with registered read data.
// Depends on sms_pkg for depth and widths.
`timescale 1ns / 1ps

module sms_store import sms_pkg::*; (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic [ADDR_W-1:0]     rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/sms_seq.sv -----
// Search sequencer: row-wise range check plus binary search, or staircase walk,
// one store read per cycle through a single shared comparator. Depends on sms_pkg.
`timescale 1ns / 1ps

module sms_seq import sms_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [KEY_WIDTH-1:0] key,
   input  sms_ctl_type                 ctl,
   output logic [ADDR_W-1:0]           rd_addr,
   input  logic [DATA_WIDTH-1:0]       rd_data,
   output logic                        idle,
   output logic                        done,
   output sms_res_type                 res,
   input  logic                        res_take
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_FIRST = 6'b000010,
      ST_LAST  = 6'b000100,
      ST_BIN   = 6'b001000,
      ST_STAIR = 6'b010000,
      ST_DONE  = 6'b100000
   } sms_state_type;

   localparam logic [CNT_W-1:0]   ONE_U = CNT_W'(1);
   localparam logic signed [CNT_W:0] ONE_S = (CNT_W + 1)'(1);

   sms_state_type           state_ff, state_in;
   logic signed [CMP_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]        dim_ff, dim_in;
   logic [CNT_W-1:0]        row_ff, row_in;
   logic [CNT_W-1:0]        col_ff, col_in;
   logic signed [CNT_W:0]   lo_ff, lo_in;
   logic signed [CNT_W:0]   hi_ff, hi_in;
   logic                    found_ff, found_in;
   logic [POS_W-1:0]        hit_row_ff, hit_row_in;
   logic [POS_W-1:0]        hit_col_ff, hit_col_in;

   logic signed [CMP_W-1:0] data_ext;
   logic                    eq;
   logic                    lt;
   logic [CNT_W-1:0]        row_next;
   logic [CNT_W-1:0]        dim_m1;
   logic signed [CNT_W:0]   mid_s;
   logic signed [CNT_W:0]   lo_step;
   logic signed [CNT_W:0]   hi_step;
   logic signed [CNT_W:0]   mid_step;
   logic [CNT_W-1:0]        rd_row;
   logic [CNT_W-1:0]        rd_col;
   logic                    advance_row;

   // Shared comparator: stored word against the key.
   assign data_ext = CMP_W'($signed(rd_data));
   assign eq       = (data_ext == key_ff);
   assign lt       = (data_ext < key_ff);

   assign row_next = row_ff + ONE_U;
   assign dim_m1   = dim_ff - ONE_U;
   assign mid_s    = $signed({1'b0, col_ff});
   assign lo_step  = lt ? (mid_s + ONE_S) : lo_ff;
   assign hi_step  = lt ? hi_ff : (mid_s - ONE_S);
   assign mid_step = lo_step + ((hi_step - lo_step) >>> 1);

   always_comb begin
      state_in    = state_ff;
      key_in      = key_ff;
      dim_in      = dim_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      found_in    = found_ff;
      hit_row_in  = hit_row_ff;
      hit_col_in  = hit_col_ff;
      rd_row      = row_ff;
      rd_col      = col_ff;
      advance_row = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in     = CMP_W'(key);
               dim_in     = ctl.dim;
               row_in     = '0;
               found_in   = 1'b0;
               hit_row_in = '0;
               hit_col_in = '0;
               rd_row     = '0;
               if (ctl.dim == '0) begin
                  state_in = ST_DONE;
               end else if (ctl.mode == MODE_STAIR) begin
                  col_in   = ctl.dim - ONE_U;
                  rd_col   = ctl.dim - ONE_U;
                  state_in = ST_STAIR;
               end else begin
                  col_in   = '0;
                  rd_col   = '0;
                  state_in = ST_FIRST;
               end
            end
         end
         ST_FIRST: begin
            // key >= first element: go check the last element
            if (lt || eq) begin
               rd_col   = dim_m1;
               state_in = ST_LAST;
            end else begin
               advance_row = 1'b1;
            end
         end
         ST_LAST: begin
            if (!lt) begin
               lo_in    = '0;
               hi_in    = $signed({1'b0, dim_m1});
               col_in   = dim_m1 >> 1;
               rd_col   = dim_m1 >> 1;
               state_in = ST_BIN;
            end else begin
               advance_row = 1'b1;
            end
         end
         ST_BIN: begin
            if (eq) begin
               found_in   = 1'b1;
               hit_row_in = POS_W'(row_ff);
               hit_col_in = POS_W'(col_ff);
               state_in   = ST_DONE;
            end else if (lo_step <= hi_step) begin
               lo_in  = lo_step;
               hi_in  = hi_step;
               col_in = mid_step[CNT_W-1:0];
               rd_col = mid_step[CNT_W-1:0];
            end else begin
               advance_row = 1'b1;
            end
         end
         ST_STAIR: begin
            if (eq) begin
               found_in   = 1'b1;
               hit_row_in = POS_W'(row_ff);
               hit_col_in = POS_W'(col_ff);
               state_in   = ST_DONE;
            end else if (lt) begin
               if (row_next == dim_ff) begin
                  state_in = ST_DONE;
               end else begin
                  row_in = row_next;
                  rd_row = row_next;
               end
            end else begin
               if (col_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  col_in = col_ff - ONE_U;
                  rd_col = col_ff - ONE_U;
               end
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Move on to the next row's first element, or finish without a hit.
      if (advance_row) begin
         if (row_next == dim_ff) begin
            state_in = ST_DONE;
         end else begin
            row_in   = row_next;
            col_in   = '0;
            rd_row   = row_next;
            rd_col   = '0;
            state_in = ST_FIRST;
         end
      end
   end

   assign rd_addr = sms_addr(rd_row[IDX_W-1:0], rd_col[IDX_W-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      dim_ff     <= dim_in;
      row_ff     <= row_in;
      col_ff     <= col_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      found_ff   <= found_in;
      hit_row_ff <= hit_row_in;
      hit_col_ff <= hit_col_in;
   end

   assign idle        = (state_ff == ST_IDLE);
   assign done        = (state_ff == ST_DONE);
   assign res.found   = found_ff;
   assign res.hit_row = hit_row_ff;
   assign res.hit_col = hit_col_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == ST_IDLE)
      else $error("search started while sequencer busy");

   a_bin_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BIN |-> (lo_ff <= hi_ff) && (mid_s >= lo_ff) && (mid_s <= hi_ff))
      else $error("binary search probe outside its window");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIRST || state_ff == ST_LAST || state_ff == ST_BIN ||
       state_ff == ST_STAIR) |-> (row_ff < dim_ff) && (col_ff < dim_ff))
      else $error("read position beyond matrix size");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !found_ff) |-> (hit_row_ff == '0) && (hit_col_ff == '0))
      else $error("miss reported with nonzero position");

   a_hold_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !res_take) |=> state_ff == ST_DONE)
      else $error("result dropped before transfer");

endmodule

// ----- hw/rtl/sorted_matrix_search.sv -----
// Sorted matrix search: a load writes the store at once and gives no result. A search takes one
// store read per cycle: in row mode up to 2 reads per skipped row and 2 + up to ceil(log2(n+1))
// per searched row; staircase mode takes at most 2n-1 reads. The single read port of the
// store and the compare in that loop set that rate; the finished result passes to the output
// register once that register is empty or being read. One search is in work at a time.
// Reset (synchronous) sets search_mode 0 and matrix_size 16; the matrix store is not cleared.
`timescale 1ns / 1ps

module sorted_matrix_search import sms_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   // input channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_command,
   input  logic [POS_W-1:0]            req_load_row,
   input  logic [POS_W-1:0]            req_load_col,
   input  logic signed [KEY_WIDTH-1:0] req_load_value,
   input  logic signed [KEY_WIDTH-1:0] req_key,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_found,
   output logic [POS_W-1:0]            rsp_hit_row,
   output logic [POS_W-1:0]            rsp_hit_col,
   // configuration write channel
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [SIZE_W-1:0]           csr_wdata
);

   logic              mode_ff, mode_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic              rsp_valid_ff, rsp_valid_in;
   sms_res_type       rsp_res_ff;

   logic              req_xfer;
   logic              csr_xfer;
   logic              start;
   logic              load_en;
   logic              load_in_range;
   logic [ADDR_W-1:0] load_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;
   logic              seq_idle;
   logic              seq_done;
   logic              res_take;
   sms_res_type       seq_res;
   sms_ctl_type       ctl;

   // ---------------------------------------------------------------------------
   // Configuration registers: always ready. The user must write only while the block is idle; the block never checks.
   // ---------------------------------------------------------------------------
   assign csr_ready = 1'b1;
   assign csr_xfer  = csr_valid && csr_ready;

   always_comb begin
      mode_in = mode_ff;
      size_in = size_ff;
      if (csr_xfer) begin
         if (csr_index == CSR_SEARCH_MODE) begin
            mode_in = csr_wdata[0];
         end else if (csr_index == CSR_MATRIX_SIZE) begin
            size_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ROW;
         size_ff <= SIZE_RESET;
      end else begin
         mode_ff <= mode_in;
         size_ff <= size_in;
      end
   end

   // Saturate the size in use to the store dimension.
   assign ctl.mode = mode_ff;
   assign ctl.dim  = (CNT_W'(size_ff) > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(size_ff);

   // ---------------------------------------------------------------------------
   // Input transfers: a load writes the store at once, a search starts the
   // sequencer. Accept only while the sequencer is idle.
   // ---------------------------------------------------------------------------
   assign req_ready = seq_idle;
   assign req_xfer  = req_valid && req_ready;
   assign start     = req_xfer && (req_command == CMD_SEARCH);

   // Drop loads whose row or column lies outside the store.
   assign load_in_range = (CNT_W'(req_load_row) < CNT_W'(MAX_DIM)) &&
                          (CNT_W'(req_load_col) < CNT_W'(MAX_DIM));
   assign load_en   = req_xfer && (req_command == CMD_LOAD) && load_in_range;
   assign load_addr = sms_addr(IDX_W'(req_load_row), IDX_W'(req_load_col));

   sms_store u_store (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (load_addr),
      .wr_data (DATA_WIDTH'(req_load_value)),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sms_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .key      (req_key),
      .ctl      (ctl),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .idle     (seq_idle),
      .done     (seq_done),
      .res      (seq_res),
      .res_take (res_take)
   );

   // ---------------------------------------------------------------------------
   // Output register: take the finished result when the slot is empty or being
   // transferred; otherwise hold it in the sequencer.
   // ---------------------------------------------------------------------------
   assign res_take = seq_done && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_res_ff <= seq_res;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_found   = rsp_res_ff.found;
   assign rsp_hit_row = rsp_res_ff.hit_row;
   assign rsp_hit_col = rsp_res_ff.hit_col;

endmodule

// ----- bench/sorted_matrix_search_tb.sv -----
// Self-checking bench for sorted_matrix_search: a directed table, then random matrix sets.
// Depends on sms_pkg and the sorted_matrix_search RTL; results are checked by a local predictor.
`timescale 1ns / 1ps

module sorted_matrix_search_tb;
   import sms_pkg::*;

   // Run limits. The settle pause is long enough to cover a whole search.
   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int          SETTLE_CYCLES = 120;
   localparam int          PHASE_ITEMS   = 375;

   // Register indexes past the two real ones; writes there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = CSR_IDX_W'(3);

   localparam logic signed [KEY_WIDTH-1:0] WORD_MIN = {1'b1, {(KEY_WIDTH-1){1'b0}}};
   localparam logic signed [KEY_WIDTH-1:0] WORD_MAX = {1'b0, {(KEY_WIDTH-1){1'b1}}};
   localparam sms_res_type                 NO_HIT   = '0;

   typedef enum logic [1:0] {STEP_CSR, STEP_LOAD, STEP_SEARCH} step_kind_type;

   typedef struct packed {
      step_kind_type        kind;
      logic [POS_W-1:0]     row;    // register index for STEP_CSR
      logic [POS_W-1:0]     col;
      logic [KEY_WIDTH-1:0] value;  // write data, load value or key
      logic                 typed;  // want holds the expected result
      sms_res_type          want;
   } step_type;

   // Directed table. Typed results are the ones that follow directly from the data:
   // size zero, single-entry matrix, and corner keys of the 2x2 set.
   localparam int DIR_N = 25;
   localparam step_type DIRECTED [DIR_N] = '{
      '{STEP_CSR,    POS_W'(CSR_MATRIX_SIZE), 4'd0,  32'd0,         1'b0, NO_HIT},
      '{STEP_SEARCH, 4'd0,                    4'd0,  32'd0,         1'b1, NO_HIT},
      '{STEP_CSR,    POS_W'(CSR_SEARCH_MODE), 4'd0,  32'd31,        1'b0, NO_HIT},
      '{STEP_SEARCH, 4'd0,                    4'd0,  WORD_MIN,      1'b1, NO_HIT},
      '{STEP_CSR,    POS_W'(CSR_SPARE_LO),    4'd0,  32'd1,         1'b0, NO_HIT},
      '{STEP_CSR,    POS_W'(CSR_SPARE_HI),    4'd0,  32'd0,         1'b0, NO_HIT},
      '{STEP_SEARCH, 4'd0,                    4'd0,  WORD_MAX,      1'b1, NO_HIT},
      '{STEP_LOAD,   4'd0,                    4'd0,  WORD_MIN,      1'b0, NO_HIT},
      '{STEP_LOAD,   4'd0,                    4'd1,  -32'sd5,       1'b0, NO_HIT},
      '{STEP_LOAD,   4'd1,                    4'd0,  32'd0,         1'b0, NO_HIT},
      '{STEP_LOAD,   4'd1,                    4'd1,  WORD_MAX,      1'b0, NO_HIT},
      '{STEP_LOAD,   4'd15,                   4'd15, 32'hFFFF_FFFF, 1'b0, NO_HIT},
      '{STEP_LOAD,   4'd15,                   4'd0,  32'h1234_5678, 1'b0, NO_HIT},
      '{STEP_CSR,    POS_W'(CSR_MATRIX_SIZE), 4'd0,  32'd2,         1'b0, NO_HIT},
      '{STEP_SEARCH, 4'd0,                    4'd0,  WORD_MAX,      1'b1, '{1'b1, 4'd1, 4'd1}},
      '{STEP_SEARCH, 4'd0,                    4'd0,  WORD_MIN,      1'b1, '{1'b1, 4'd0, 4'd0}},
      '{STEP_SEARCH, 4'd0,                    4'd0,  32'd0,         1'b0, NO_HIT},
      '{STEP_SEARCH, 4'd0,                    4'd0,  32'd7,         1'b0, NO_HIT},
      '{STEP_CSR,    POS_W'(CSR_SEARCH_MODE), 4'd0,  32'd30,        1'b0, NO_HIT},
      '{STEP_SEARCH, 4'd0,                    4'd0,  WORD_MIN,      1'b1, '{1'b1, 4'd0, 4'd0}},
      '{STEP_SEARCH, 4'd0,                    4'd0,  -32'sd5,       1'b0, NO_HIT},
      '{STEP_SEARCH, 4'd0,                    4'd0,  32'h7FFF_FFFE, 1'b0, NO_HIT},
      '{STEP_CSR,    POS_W'(CSR_MATRIX_SIZE), 4'd0,  32'd1,         1'b0, NO_HIT},
      '{STEP_SEARCH, 4'd0,                    4'd0,  WORD_MIN,      1'b1, '{1'b1, 4'd0, 4'd0}},
      '{STEP_SEARCH, 4'd0,                    4'd0,  WORD_MAX,      1'b1, NO_HIT}
   };

   // Block ports; every input starts at a known value.
   logic                        clock          = 1'b0;
   logic                        reset          = 1'b1;
   logic                        req_valid      = 1'b0;
   logic                        req_ready;
   logic                        req_command    = CMD_LOAD;
   logic [POS_W-1:0]            req_load_row   = '0;
   logic [POS_W-1:0]            req_load_col   = '0;
   logic signed [KEY_WIDTH-1:0] req_load_value = '0;
   logic signed [KEY_WIDTH-1:0] req_key        = '0;
   logic                        rsp_valid;
   logic                        rsp_ready      = 1'b0;
   logic                        rsp_found;
   logic [POS_W-1:0]            rsp_hit_row;
   logic [POS_W-1:0]            rsp_hit_col;
   logic                        csr_valid      = 1'b0;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index      = '0;
   logic [SIZE_W-1:0]           csr_wdata      = '0;

   // Mirror of the block's state as the predictor sees it.
   logic signed [DATA_WIDTH-1:0] mirror_cells [MAX_DIM][MAX_DIM];
   bit                           cell_written [MAX_DIM][MAX_DIM];
   logic                         mirror_mode;
   logic [SIZE_W-1:0]            mirror_size;

   // Matrix contents planned for the current random set.
   logic signed [KEY_WIDTH-1:0]  plan_cells [MAX_DIM][MAX_DIM];

   sms_res_type awaited_hits [$];   // one entry per accepted search, oldest first
   sms_res_type oldest_hit;
   int          fault_count = 0;
   int          items_sent  = 0;
   int          idle_pct    = 0;    // chance per cycle that the sender holds off
   int          stall_pct   = 0;    // chance per cycle that the receiver stalls
   int unsigned cycle_count;

   sorted_matrix_search DUT (.*);

   // 2 ns clock: low then high, first rising edge at 1 ns.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predict the result of one search from the mirrored matrix and registers.
   function automatic sms_res_type locate_key(input logic signed [KEY_WIDTH-1:0] key);
      sms_res_type res;
      int          n, r, c, lo, hi, mid;
      res = '0;
      n = (mirror_size > MAX_DIM) ? MAX_DIM : int'(mirror_size);
      if (n > 0 && mirror_mode == MODE_ROW) begin
         // scan rows in order; binary-search only rows whose ends bracket the key
         for (r = 0; r < n && !res.found; r++) begin
            if (key >= mirror_cells[r][0] && key <= mirror_cells[r][n-1]) begin
               lo = 0;
               hi = n - 1;
               while (lo <= hi && !res.found) begin
                  mid = lo + (hi - lo) / 2;
                  if (mirror_cells[r][mid] == key) begin
                     res = '{1'b1, POS_W'(r), POS_W'(mid)};
                  end else if (mirror_cells[r][mid] < key) begin
                     lo = mid + 1;
                  end else begin
                     hi = mid - 1;
                  end
               end
            end
         end
      end else if (n > 0) begin
         // staircase: start top-right, step down on a smaller cell, left on a larger one
         r = 0;
         c = n - 1;
         while (r < n && c >= 0 && !res.found) begin
            if (mirror_cells[r][c] == key) begin
               res = '{1'b1, POS_W'(r), POS_W'(c)};
            end else if (mirror_cells[r][c] < key) begin
               r++;
            end else begin
               c--;
            end
         end
      end
      return res;
   endfunction

   // Offer one item on the request channel and hold it until the transfer.
   // Fields the command does not use carry random data.
   task automatic send_item(input logic cmd, input logic [POS_W-1:0] row, col,
                            input logic signed [KEY_WIDTH-1:0] value, key,
                            input bit typed, input sms_res_type want);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_load_row   <= (cmd == CMD_LOAD) ? row   : POS_W'($urandom);
      req_load_col   <= (cmd == CMD_LOAD) ? col   : POS_W'($urandom);
      req_load_value <= (cmd == CMD_LOAD) ? value : KEY_WIDTH'($urandom);
      req_key        <= (cmd == CMD_SEARCH) ? key : KEY_WIDTH'($urandom);
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (cmd == CMD_LOAD) begin
         mirror_cells[row][col] = DATA_WIDTH'(value);
         cell_written[row][col] = 1'b1;
      end else begin
         awaited_hits.push_back(typed ? want : locate_key(key));
      end
   endtask

   // Write one register once the block has drained: drop valid, wait for every
   // outstanding result, let a full search time pass, then make the transfer.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [SIZE_W-1:0] data);
      req_valid <= 1'b0;
      while (awaited_hits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_SEARCH_MODE: mirror_mode = data[0];
         CSR_MATRIX_SIZE: mirror_size = data;
         default: ;
      endcase
   endtask

   // One random set: new registers, usually a fresh matrix, then a run of searches.
   task automatic run_random_set();
      int                          size_cfg, n, pick, r, c;
      int unsigned                 spread;
      longint                      base, level;
      bit                          reuse, sorted;
      logic signed [KEY_WIDTH-1:0] word, key;

      // Keep most sets small; sizes past MAX_DIM saturate in the block.
      pick = $urandom_range(99);
      if (pick < 3)
         size_cfg = 0;
      else if (pick < 58)
         size_cfg = $urandom_range(4, 1);
      else if (pick < 83)
         size_cfg = $urandom_range(8, 5);
      else if (pick < 94)
         size_cfg = $urandom_range(16, 9);
      else
         size_cfg = $urandom_range(31, 17);
      n = (size_cfg > MAX_DIM) ? MAX_DIM : size_cfg;

      if ($urandom_range(9) == 0)
         write_reg($urandom_range(1) ? CSR_SPARE_HI : CSR_SPARE_LO, SIZE_W'($urandom));
      // mode data is fully random: only bit 0 counts
      if ($urandom_range(1)) begin
         write_reg(CSR_MATRIX_SIZE, SIZE_W'(size_cfg));
         write_reg(CSR_SEARCH_MODE, SIZE_W'($urandom));
      end else begin
         write_reg(CSR_SEARCH_MODE, SIZE_W'($urandom));
         write_reg(CSR_MATRIX_SIZE, SIZE_W'(size_cfg));
      end

      // Reuse the stored matrix now and then, but only if the whole region was written.
      reuse = ($urandom_range(3) == 0);
      for (r = 0; r < n; r++)
         for (c = 0; c < n; c++)
            if (!cell_written[r][c])
               reuse = 1'b0;

      if (!reuse) begin
         sorted = ($urandom_range(4) != 0);
         word   = $urandom;
         case ($urandom_range(3))
            0:       base = WORD_MIN;
            1:       base = word;
            2:       base = longint'($urandom_range(200)) - 100;
            default: base = longint'(WORD_MAX) - longint'($urandom_range(50));
         endcase
         case ($urandom_range(2))
            0:       spread = 2;          // many duplicates
            1:       spread = 1000;
            default: spread = 1 << 26;    // wide steps, clamps near the top
         endcase
         for (r = 0; r < n; r++) begin
            for (c = 0; c < n; c++) begin
               if (!sorted) begin
                  plan_cells[r][c] = $urandom;
               end else if (r == 0 && c == 0) begin
                  plan_cells[r][c] = base[KEY_WIDTH-1:0];
               end else begin
                  // grow from the larger of the upper and left neighbors
                  level = WORD_MIN;
                  if (r > 0)
                     level = plan_cells[r-1][c];
                  if (c > 0 && plan_cells[r][c-1] > level)
                     level = plan_cells[r][c-1];
                  level += longint'($urandom_range(spread));
                  if (level > longint'(WORD_MAX))
                     level = WORD_MAX;
                  plan_cells[r][c] = level[KEY_WIDTH-1:0];
               end
               // scatter an occasional stray load anywhere in the store
               if ($urandom_range(19) == 0)
                  send_item(CMD_LOAD, POS_W'($urandom), POS_W'($urandom), $urandom,
                            '0, 1'b0, NO_HIT);
               send_item(CMD_LOAD, POS_W'(r), POS_W'(c), plan_cells[r][c], '0, 1'b0, NO_HIT);
            end
         end
      end

      repeat ($urandom_range(12, 3)) begin
         // rarely overwrite a cell in use, which can break the ordering
         if (n > 0 && $urandom_range(19) == 0)
            send_item(CMD_LOAD, POS_W'($urandom_range(n - 1)), POS_W'($urandom_range(n - 1)),
                      $urandom, '0, 1'b0, NO_HIT);
         pick = $urandom_range(99);
         key  = $urandom;
         r    = (n > 0) ? $urandom_range(n - 1) : 0;
         c    = (n > 0) ? $urandom_range(n - 1) : 0;
         if (pick >= 90) begin
            case ($urandom_range(2))
               0:       key = WORD_MIN;
               1:       key = WORD_MAX;
               default: key = '0;
            endcase
         end else if (n > 0 && pick < 60) begin
            key = mirror_cells[r][c];
         end else if (n > 0 && pick < 80) begin
            key = (pick % 2) ? mirror_cells[r][c] + 1 : mirror_cells[r][c] - 1;
         end
         send_item(CMD_SEARCH, '0, '0, '0, key, 1'b0, NO_HIT);
      end
   endtask

   // Result side: check every transfer against the oldest prediction, then pick
   // the ready level for the next cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_hits.size() == 0) begin
            $error("result transfer with no search outstanding");
            fault_count++;
         end else begin
            oldest_hit = awaited_hits.pop_front();
            if (rsp_found !== oldest_hit.found) begin
               $error("found: expected %0d, actual %0d", oldest_hit.found, rsp_found);
               fault_count++;
            end
            if (rsp_hit_row !== oldest_hit.hit_row) begin
               $error("hit_row: expected %0d, actual %0d", oldest_hit.hit_row, rsp_hit_row);
               fault_count++;
            end
            if (rsp_hit_col !== oldest_hit.hit_col) begin
               $error("hit_col: expected %0d, actual %0d", oldest_hit.hit_col, rsp_hit_col);
               fault_count++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Stimulus: reset, directed table, four idling phases of random sets, drain.
   initial begin
      int       phase, phase_start, i;
      step_type step;

      mirror_mode = MODE_ROW;
      mirror_size = SIZE_RESET;

      // hold reset at the start, then release it
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_N; i++) begin
         step = DIRECTED[i];
         case (step.kind)
            STEP_CSR:
               write_reg(CSR_IDX_W'(step.row), SIZE_W'(step.value));
            STEP_LOAD:
               send_item(CMD_LOAD, step.row, step.col, step.value, '0, 1'b0, NO_HIT);
            default:
               send_item(CMD_SEARCH, '0, '0, '0, step.value, step.typed, step.want);
         endcase
      end

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 69;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 69;
            end
            default: begin
               idle_pct  = 10;
               stall_pct = 10;
            end
         endcase
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS)
            run_random_set();
      end

      // drop valid, drain outstanding results, then watch a while for strays
      req_valid <= 1'b0;
      while (awaited_hits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog: end the run if a transfer never comes.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $error("cycle limit reached, %0d results still awaited", awaited_hits.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- sorted_matrix_search.f -----
hw/rtl/sms_pkg.sv
hw/rtl/sms_store.sv
hw/rtl/sms_seq.sv
hw/rtl/sorted_matrix_search.sv
bench/sorted_matrix_search_tb.sv
